### design/urf_pkg.sv
package urf_pkg;

  typedef enum logic [1:0] {
    VAR_8250    = 2'd0,
    VAR_16450   = 2'd1,
    VAR_16550   = 2'd2,
    VAR_16550A  = 2'd3
  } urf_variant_t;

  typedef enum logic [2:0] {
    OFS_RBR_DLL = 3'd0,
    OFS_IER_DLM = 3'd1,
    OFS_IIR_FCR = 3'd2,
    OFS_LCR     = 3'd3,
    OFS_MCR     = 3'd4,
    OFS_LSR     = 3'd5,
    OFS_MSR     = 3'd6,
    OFS_SCR     = 3'd7
  } urf_offset_t;

  localparam logic [7:0] IIR_NO_INT      = 8'h01;
  localparam logic [7:0] IIR_FIFO_16550A = 8'hC0;
  localparam logic [7:0] IIR_FIFO_16550  = 8'h80;
  localparam logic [7:0] LSR_IDLE        = 8'h60;
  localparam logic [7:0] SCR_ABSENT      = 8'hFF;
  localparam logic [3:0] DELTA_ANY_EDGE  = 4'hB;

  typedef struct packed {
    logic        valid;
    logic        wr;
    urf_offset_t ofs;
    logic [7:0]  wdata;
    logic [3:0]  pins;
  } urf_item_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       dtr;
    logic       rts;
    logic       out2;
  } urf_result_t;

endpackage

### design/urf_in_stage.sv
module urf_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_tuser,
  input  logic [15:0]       in_tdata,
  input  logic              advance,
  output urf_pkg::urf_item_t item
);

  logic             valid_r;
  logic             valid_nxt;
  logic             wr_r;
  logic [2:0]       ofs_r;
  logic [7:0]       wdata_r;
  logic [3:0]       pins_r;
  logic             in_fire;

  assign in_tready = !valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    if (in_fire) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      wr_r    <= in_tuser;
      ofs_r   <= in_tdata[2:0];
      wdata_r <= in_tdata[10:3];
      pins_r  <= in_tdata[14:11];
    end
  end

  assign item.valid = valid_r;
  assign item.wr    = wr_r;
  assign item.ofs   = urf_pkg::urf_offset_t'(ofs_r);
  assign item.wdata = wdata_r;
  assign item.pins  = pins_r;

endmodule

### design/urf_core.sv
module urf_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [1:0]           cfg_data,
  input  urf_pkg::urf_item_t   item,
  input  logic                 fire,
  output urf_pkg::urf_result_t result
);

  urf_pkg::urf_variant_t variant_r;
  logic [7:0] dll_r,  dll_nxt;
  logic [7:0] dlm_r,  dlm_nxt;
  logic [3:0] ier_r,  ier_nxt;
  logic [7:0] lcr_r,  lcr_nxt;
  logic [4:0] mcr_r,  mcr_nxt;
  logic [7:0] scr_r,  scr_nxt;
  logic       fifo_on_r, fifo_on_nxt;
  logic [3:0] delta_r, delta_nxt;
  logic [3:0] lines_r, lines_nxt;
  logic [3:0] delta_acc;
  logic [7:0] rdata;
  logic       dlab;
  logic       loop_nxt;

  assign dlab = lcr_r[7];

  always_comb begin
    if (mcr_r[4]) begin
      lines_nxt = {mcr_r[3], mcr_r[2], mcr_r[0], mcr_r[1]};
    end else begin
      lines_nxt = item.pins;
    end
    delta_acc    = delta_r | ((lines_nxt ^ lines_r) & urf_pkg::DELTA_ANY_EDGE);
    delta_acc[2] = delta_r[2] | (lines_r[2] & !lines_nxt[2]);
  end

  always_comb begin
    dll_nxt     = dll_r;
    dlm_nxt     = dlm_r;
    ier_nxt     = ier_r;
    lcr_nxt     = lcr_r;
    mcr_nxt     = mcr_r;
    scr_nxt     = scr_r;
    fifo_on_nxt = fifo_on_r;
    delta_nxt   = delta_acc;
    rdata       = 8'h00;
    if (item.wr) begin
      unique case (item.ofs)
        urf_pkg::OFS_RBR_DLL: begin
          if (dlab) begin
            dll_nxt = item.wdata;
          end
        end
        urf_pkg::OFS_IER_DLM: begin
          if (dlab) begin
            dlm_nxt = item.wdata;
          end else begin
            ier_nxt = item.wdata[3:0];
          end
        end
        urf_pkg::OFS_IIR_FCR: begin
          if (variant_r == urf_pkg::VAR_16550 || variant_r == urf_pkg::VAR_16550A) begin
            fifo_on_nxt = item.wdata[0];
          end
        end
        urf_pkg::OFS_LCR: begin
          lcr_nxt = item.wdata;
        end
        urf_pkg::OFS_MCR: begin
          mcr_nxt = item.wdata[4:0];
        end
        urf_pkg::OFS_SCR: begin
          if (variant_r != urf_pkg::VAR_8250) begin
            scr_nxt = item.wdata;
          end
        end
        default: begin
        end
      endcase
    end else begin
      unique case (item.ofs)
        urf_pkg::OFS_RBR_DLL: begin
          rdata = dlab ? dll_r : 8'h00;
        end
        urf_pkg::OFS_IER_DLM: begin
          rdata = dlab ? dlm_r : {4'h0, ier_r};
        end
        urf_pkg::OFS_IIR_FCR: begin
          rdata = urf_pkg::IIR_NO_INT;
          if (fifo_on_r && variant_r == urf_pkg::VAR_16550A) begin
            rdata = rdata | urf_pkg::IIR_FIFO_16550A;
          end else if (fifo_on_r && variant_r == urf_pkg::VAR_16550) begin
            rdata = rdata | urf_pkg::IIR_FIFO_16550;
          end
        end
        urf_pkg::OFS_LCR: begin
          rdata = lcr_r;
        end
        urf_pkg::OFS_MCR: begin
          rdata = {3'b000, mcr_r};
        end
        urf_pkg::OFS_LSR: begin
          rdata = urf_pkg::LSR_IDLE;
        end
        urf_pkg::OFS_MSR: begin
          rdata     = {lines_nxt, delta_acc};
          delta_nxt = 4'h0;
        end
        urf_pkg::OFS_SCR: begin
          rdata = (variant_r != urf_pkg::VAR_8250) ? scr_r : urf_pkg::SCR_ABSENT;
        end
        default: begin
        end
      endcase
    end
  end

  assign loop_nxt      = mcr_nxt[4];
  assign result.rdata  = rdata;
  assign result.dtr    = mcr_nxt[0] && !loop_nxt;
  assign result.rts    = mcr_nxt[1] && !loop_nxt;
  assign result.out2   = mcr_nxt[3] && !loop_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r <= urf_pkg::VAR_16550A;
    end else if (cfg_valid) begin
      variant_r <= urf_pkg::urf_variant_t'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dll_r     <= 8'h00;
      dlm_r     <= 8'h00;
      ier_r     <= 4'h0;
      lcr_r     <= 8'h00;
      mcr_r     <= 5'h00;
      scr_r     <= 8'h00;
      fifo_on_r <= 1'b0;
      delta_r   <= 4'h0;
      lines_r   <= 4'h0;
    end else if (fire && item.valid) begin
      dll_r     <= dll_nxt;
      dlm_r     <= dlm_nxt;
      ier_r     <= ier_nxt;
      lcr_r     <= lcr_nxt;
      mcr_r     <= mcr_nxt;
      scr_r     <= scr_nxt;
      fifo_on_r <= fifo_on_nxt;
      delta_r   <= delta_nxt;
      lines_r   <= lines_nxt;
    end
  end

endmodule

### design/urf_out_stage.sv
module urf_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  urf_pkg::urf_result_t result,
  output logic                 free,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata
);

  logic                 valid_r;
  logic                 valid_nxt;
  urf_pkg::urf_result_t result_r;

  assign free = !valid_r || out_tready;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {5'b00000, result_r.out2, result_r.rts, result_r.dtr, result_r.rdata};

endmodule

### design/uart_register_file.sv
// Channel  Direction  Handshake                   Payload
// in       slave      in_tvalid / in_tready        in_tuser, in_tdata (one register access)
// out      master     out_tvalid / out_tready      out_tdata (read byte and modem outputs)
// cfg      slave      cfg_valid / cfg_ready        cfg_data (UART variant)
//
// Each access passes an input register and then a result register; one access is taken
// every cycle while results drain.
// A stalled result holds the input register, and in_tready drops only then.
// Reset is synchronous on rst_n and restores the 16550A variant with all registers zero.
// Configuration is always ready and takes effect on the next cycle.
module uart_register_file (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,   // [0] operation
  input  logic [15:0] in_tdata,   // [2:0] reg_offset, [10:3] write_data, [11] cts_pin,
                                  // [12] dsr_pin, [13] ring_pin, [14] carrier_pin
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] read_data, [8] dtr_out, [9] rts_out,
                                  // [10] irq_enable_out
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data
);

  urf_pkg::urf_item_t   item;
  urf_pkg::urf_result_t result;
  logic                 free;
  logic                 fire;

  assign cfg_ready = 1'b1;
  assign fire      = item.valid && free;

  urf_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .advance   (free),
    .item      (item)
  );

  urf_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .item      (item),
    .fire      (fire),
    .result    (result)
  );

  urf_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .result     (result),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam bit OP_READ     = 1'b0;
  localparam bit OP_WRITE    = 1'b1;
  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_ITEMS = 190;
  localparam int LONG_HOLD   = 150;

  // Shadow copy of the UART registers; every accepted access queues the reply it must produce.
  class register_mirror;
    urf_pkg::urf_variant_t variant;
    logic [7:0]            dll;
    logic [7:0]            dlm;
    logic [3:0]            ier;
    logic [7:0]            lcr;
    logic [4:0]            mcr;
    logic [7:0]            scr;
    logic                  fifo_en;
    logic [3:0]            msr_delta;
    logic [3:0]            msr_prev;
    urf_pkg::urf_result_t  pending_replies[$];
    int                    mismatches;

    function new();
      variant    = urf_pkg::VAR_16550A;
      dll        = '0;
      dlm        = '0;
      ier        = '0;
      lcr        = '0;
      mcr        = '0;
      scr        = '0;
      fifo_en    = 1'b0;
      msr_delta  = '0;
      msr_prev   = '0;
      mismatches = 0;
    endfunction

    function void apply_access(bit wr, urf_pkg::urf_offset_t ofs, logic [7:0] wdata,
                               logic [3:0] pins);
      logic [3:0]           lines;
      logic [7:0]           rd;
      bit                   dlab;
      urf_pkg::urf_result_t reply;
      dlab = lcr[7];
      rd = 8'h00;
      if (mcr[4]) begin
        lines = {mcr[3], mcr[2], mcr[0], mcr[1]};
      end else begin
        lines = pins;
      end
      msr_delta = msr_delta | ((lines ^ msr_prev) & urf_pkg::DELTA_ANY_EDGE);
      if (msr_prev[2] && !lines[2]) begin
        msr_delta[2] = 1'b1;
      end
      msr_prev = lines;
      if (wr == OP_WRITE) begin
        case (ofs)
          urf_pkg::OFS_RBR_DLL: if (dlab) dll = wdata;
          urf_pkg::OFS_IER_DLM: begin
            if (dlab) dlm = wdata;
            else ier = wdata[3:0];
          end
          urf_pkg::OFS_IIR_FCR: begin
            if (variant == urf_pkg::VAR_16550 || variant == urf_pkg::VAR_16550A) begin
              fifo_en = wdata[0];
            end
          end
          urf_pkg::OFS_LCR: lcr = wdata;
          urf_pkg::OFS_MCR: mcr = wdata[4:0];
          urf_pkg::OFS_SCR: if (variant != urf_pkg::VAR_8250) scr = wdata;
          default: ;
        endcase
      end else begin
        case (ofs)
          urf_pkg::OFS_RBR_DLL: rd = dlab ? dll : 8'h00;
          urf_pkg::OFS_IER_DLM: rd = dlab ? dlm : {4'h0, ier};
          urf_pkg::OFS_IIR_FCR: begin
            rd = urf_pkg::IIR_NO_INT;
            if (fifo_en && variant == urf_pkg::VAR_16550A) begin
              rd = rd | urf_pkg::IIR_FIFO_16550A;
            end else if (fifo_en && variant == urf_pkg::VAR_16550) begin
              rd = rd | urf_pkg::IIR_FIFO_16550;
            end
          end
          urf_pkg::OFS_LCR: rd = lcr;
          urf_pkg::OFS_MCR: rd = {3'b000, mcr};
          urf_pkg::OFS_LSR: rd = urf_pkg::LSR_IDLE;
          urf_pkg::OFS_MSR: begin
            rd = {lines, msr_delta};
            msr_delta = 4'h0;
          end
          default: rd = (variant != urf_pkg::VAR_8250) ? scr : urf_pkg::SCR_ABSENT;
        endcase
      end
      reply.rdata = rd;
      reply.dtr   = mcr[4] ? 1'b0 : mcr[0];
      reply.rts   = mcr[4] ? 1'b0 : mcr[1];
      reply.out2  = mcr[4] ? 1'b0 : mcr[3];
      pending_replies.push_back(reply);
    endfunction

    function void compare_reply(logic [15:0] tdata);
      urf_pkg::urf_result_t want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected reply %h with nothing outstanding", tdata);
        return;
      end
      want = pending_replies.pop_front();
      if (tdata[7:0] !== want.rdata || tdata[8] !== want.dtr || tdata[9] !== want.rts ||
          tdata[10] !== want.out2) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("reply mismatch: expected rd=%h dtr=%b rts=%b out2=%b,",
                   want.rdata, want.dtr, want.rts, want.out2,
                   " got rd=%h dtr=%b rts=%b out2=%b",
                   tdata[7:0], tdata[8], tdata[9], tdata[10]);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic        in_tuser = 1'b0;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_data = '0;

  register_mirror mirror = new();
  int             idle_cycles = 0;
  int             hold_request = 0;
  bit             no_gaps = 1'b0;

  uart_register_file u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      mirror.variant = urf_pkg::urf_variant_t'(cfg_data);
    end
    if (rst_n && in_tvalid && in_tready) begin
      mirror.apply_access(in_tuser, urf_pkg::urf_offset_t'(in_tdata[2:0]), in_tdata[10:3],
                          in_tdata[14:11]);
    end
    if (rst_n && out_tvalid && out_tready) begin
      mirror.compare_reply(out_tdata);
    end
    if (rst_n && ((cfg_valid && cfg_ready) || (in_tvalid && in_tready) ||
                  (out_tvalid && out_tready))) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end else if (no_gaps) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 6);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  task automatic send_access(bit wr, urf_pkg::urf_offset_t ofs, logic [7:0] wdata,
                             logic [3:0] pins);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= wr;
    in_tdata  <= {1'b0, pins, wdata, ofs};
    do @(posedge clk); while (!(in_tvalid && in_tready));
  endtask

  task automatic wait_drained();
    while (mirror.pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_variant(urf_pkg::urf_variant_t v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_accesses(int count);
    int                   i;
    logic [3:0]           pins;
    bit                   wr;
    urf_pkg::urf_offset_t ofs;
    logic [7:0]           wdata;
    pins = 4'($urandom);
    for (i = 0; i < count; i++) begin
      if (i % 97 == 50) begin
        // Let the block run dry before carrying on.
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (mirror.pending_replies.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 3) == 0) pins = pins ^ 4'($urandom);
      wr    = 1'($urandom_range(0, 1));
      ofs   = urf_pkg::urf_offset_t'($urandom_range(0, 7));
      wdata = 8'($urandom);
      send_access(wr, ofs, wdata, pins);
    end
    in_tvalid <= 1'b0;
  endtask

  initial begin
    urf_pkg::urf_variant_t phase_variant[7];
    int                    p;
    phase_variant[0] = urf_pkg::VAR_8250;
    phase_variant[1] = urf_pkg::VAR_16450;
    phase_variant[2] = urf_pkg::VAR_16550;
    phase_variant[3] = urf_pkg::VAR_16550A;
    phase_variant[4] = urf_pkg::urf_variant_t'($urandom_range(0, 3));
    phase_variant[5] = urf_pkg::urf_variant_t'($urandom_range(0, 3));
    phase_variant[6] = urf_pkg::urf_variant_t'($urandom_range(0, 3));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_variant(urf_pkg::VAR_16550A);

    send_access(OP_READ,  urf_pkg::OFS_SCR,     8'h00, 4'h0);
    send_access(OP_WRITE, urf_pkg::OFS_LCR,     8'h80, 4'h0);
    send_access(OP_WRITE, urf_pkg::OFS_RBR_DLL, 8'hFF, 4'h0);
    send_access(OP_WRITE, urf_pkg::OFS_IER_DLM, 8'hAA, 4'h0);
    send_access(OP_READ,  urf_pkg::OFS_RBR_DLL, 8'h00, 4'h0);
    send_access(OP_READ,  urf_pkg::OFS_IER_DLM, 8'h00, 4'h0);
    send_access(OP_WRITE, urf_pkg::OFS_LCR,     8'h03, 4'hF);
    send_access(OP_READ,  urf_pkg::OFS_RBR_DLL, 8'hFF, 4'hF);
    send_access(OP_WRITE, urf_pkg::OFS_IER_DLM, 8'hFF, 4'hF);
    send_access(OP_READ,  urf_pkg::OFS_IER_DLM, 8'h00, 4'hF);
    send_access(OP_WRITE, urf_pkg::OFS_IIR_FCR, 8'hC7, 4'hF);
    send_access(OP_READ,  urf_pkg::OFS_IIR_FCR, 8'h00, 4'h4);
    send_access(OP_READ,  urf_pkg::OFS_MSR,     8'h00, 4'h0);
    send_access(OP_READ,  urf_pkg::OFS_MSR,     8'h00, 4'h0);
    send_access(OP_WRITE, urf_pkg::OFS_MCR,     8'hFF, 4'h0);
    send_access(OP_READ,  urf_pkg::OFS_MSR,     8'h00, 4'h5);
    send_access(OP_READ,  urf_pkg::OFS_MCR,     8'h00, 4'h0);
    send_access(OP_WRITE, urf_pkg::OFS_MCR,     8'h0B, 4'h0);
    send_access(OP_READ,  urf_pkg::OFS_LSR,     8'h00, 4'hA);
    send_access(OP_WRITE, urf_pkg::OFS_LSR,     8'h55, 4'h0);
    send_access(OP_WRITE, urf_pkg::OFS_MSR,     8'hAA, 4'h0);
    send_access(OP_WRITE, urf_pkg::OFS_SCR,     8'h55, 4'h0);
    send_access(OP_READ,  urf_pkg::OFS_SCR,     8'h00, 4'h0);
    send_access(OP_WRITE, urf_pkg::OFS_IIR_FCR, 8'h00, 4'h0);
    send_access(OP_READ,  urf_pkg::OFS_IIR_FCR, 8'h00, 4'h0);
    in_tvalid <= 1'b0;

    for (p = 0; p < 7; p++) begin
      wait_drained();
      write_variant(phase_variant[p]);
      no_gaps = (p % 3 == 1);
      if (p == 1) hold_request = LONG_HOLD;
      random_accesses(PHASE_ITEMS);
    end
    no_gaps = 1'b0;

    wait_drained();
    repeat (8) @(posedge clk);
    if (mirror.mismatches == 0 && mirror.pending_replies.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
